// File: rtl/tvtg_pkg.sv
// Shared types and constants for the two-voice tone generator.
// Used by every module of the block; depends on nothing else.
package tvtg_pkg;

    localparam int NUM_VOICES_DEF = 2;

    // Field widths of the input and result beats.
    localparam int KIND_W = 2;
    localparam int FREQ_W = 15;
    localparam int LEN_W  = 16;
    localparam int EL_W   = 16;

    // Voice state widths: signed remaining time, half period and tick count.
    localparam int REM_W = 18;
    localparam int CNT_W = 19;

    // Divider: 1000000 / (2 * frequency), one quotient bit per cycle.
    localparam int TICKS_PER_SEC = 1000000;
    localparam int NUM_W         = 20;
    localparam int DEN_W         = FREQ_W + 2;
    localparam int DIV_STEPS     = NUM_W;
    localparam int DS_W          = $clog2(DIV_STEPS);

    // Bit counter of the serial update pass.
    localparam int K_W = $clog2(CNT_W);

    localparam logic [KIND_W-1:0] KIND_PLAY    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ELAPSED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SER,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [FREQ_W-1:0] frequency;
        logic [LEN_W-1:0]  length;
        logic [EL_W-1:0]   elapsed;
    } t_in;

    typedef struct packed {
        logic speaker_one_level;
        logic speaker_two_level;
        logic voice_one_active;
        logic voice_two_active;
        logic note_dropped;
    } t_out;

    // Control from the sequencer to one voice lane.
    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] half;
        logic [LEN_W-1:0] len;
        logic             step_tick;
        logic             step_el;
        logic             first;
        logic             rem_last;
        logic             cnt_last;
        logic             el_bit;
    } t_vctl;

    typedef struct packed {
        logic busy;
        logic pin;
    } t_vstat;

endpackage

// File: rtl/tvtg_div.sv
// Restoring divider that forms the half period 1000000 / (2 * frequency).
// One quotient bit per cycle; depends on tvtg_pkg.
module tvtg_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [tvtg_pkg::FREQ_W-1:0] i_freq,
    output logic                      o_done,
    output logic [tvtg_pkg::CNT_W-1:0]  o_quot
);
    import tvtg_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [DS_W-1:0]     r_step;
    logic [DEN_W-1:0]    r_den;
    logic [DEN_W-1:0]    r_rem;
    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    r_quot;

    logic [DEN_W:0]      w_trial;
    logic [DEN_W:0]      w_diff;
    logic                w_ge;
    logic [DEN_W-1:0]    n_rem;
    logic [FREQ_W-1:0]   w_freq;

    always_comb begin
        w_trial = {r_rem, r_num[NUM_W-1]};
        w_diff  = w_trial - {1'b0, r_den};
        w_ge    = (w_trial >= {1'b0, r_den});
        n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        // A zero frequency plays as 1 Hz.
        w_freq  = (i_freq == '0) ? FREQ_W'(1) : i_freq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_den  <= {1'b0, w_freq, 1'b0};
                r_rem  <= '0;
                r_num  <= NUM_W'(TICKS_PER_SEC);
                r_quot <= '0;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_quot <= {r_quot[NUM_W-2:0], w_ge};
                r_step <= r_step + 1'b1;
                if (r_step == DS_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot[CNT_W-1:0];

endmodule

// File: rtl/tvtg_voice.sv
// One voice lane: busy flag, remaining time, half period, tick count and levels.
// Updates run bit-serially, LSB first, over rotating registers; depends on tvtg_pkg.
module tvtg_voice (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tvtg_pkg::t_vctl  i_ctl,
    output tvtg_pkg::t_vstat o_stat
);
    import tvtg_pkg::*;

    logic             r_busy;
    logic             r_pend;
    logic             r_pin;
    logic [REM_W-1:0] r_rem;
    logic [CNT_W-1:0] r_half;
    logic [CNT_W-1:0] r_cnt;
    logic             r_c;
    logic             r_b;
    logic             r_nz;

    logic w_cin, w_sum, w_cout, w_bin_c, w_bout_c;
    logic w_bin_r, w_diff, w_bout_r, w_nz;

    always_comb begin
        // Tick pass: count + 1, then a serial compare against the half period.
        w_cin    = i_ctl.first ? 1'b1 : r_c;
        w_sum    = r_cnt[0] ^ w_cin;
        w_cout   = r_cnt[0] & w_cin;
        w_bin_c  = i_ctl.first ? 1'b0 : r_b;
        w_bout_c = (~w_sum & r_half[0]) | (~(w_sum ^ r_half[0]) & w_bin_c);
        // Elapsed pass: remaining - elapsed, tracking whether any bit is set.
        w_bin_r  = i_ctl.first ? 1'b0 : r_c;
        w_diff   = r_rem[0] ^ i_ctl.el_bit ^ w_bin_r;
        w_bout_r = (~r_rem[0] & i_ctl.el_bit) | (~(r_rem[0] ^ i_ctl.el_bit) & w_bin_r);
        w_nz     = (i_ctl.first ? 1'b0 : r_nz) | w_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pend <= 1'b0;
            r_pin  <= 1'b0;
        end else if (i_ctl.load) begin
            r_busy <= 1'b1;
            r_half <= i_ctl.half;
            r_rem  <= REM_W'(i_ctl.len);
            r_cnt  <= '0;
        end else if (i_ctl.step_tick) begin
            r_half <= {r_half[0], r_half[CNT_W-1:1]};
            r_c    <= w_cout;
            r_b    <= w_bout_c;
            // No borrow out of the top bit means the new count reached the half period.
            if (i_ctl.cnt_last && r_busy && !w_bout_c) begin
                r_cnt  <= '0;
                r_pin  <= r_pend;
                r_pend <= ~r_pend;
            end else begin
                r_cnt  <= {(r_busy ? w_sum : r_cnt[0]), r_cnt[CNT_W-1:1]};
            end
        end else if (i_ctl.step_el) begin
            r_rem <= {(r_busy ? w_diff : r_rem[0]), r_rem[REM_W-1:1]};
            r_c   <= w_bout_r;
            r_nz  <= w_nz;
            // On the top bit w_diff is the sign; negative or all zero frees the voice.
            if (i_ctl.rem_last && r_busy && (w_diff || !w_nz)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.pin  = r_pin;

endmodule

// File: rtl/two_voice_tone_generator_unit.sv
// Two-voice square-wave tone generator, top level.
// Depends on tvtg_pkg, tvtg_div and tvtg_voice.
//
// Input channel (i_in_valid / o_in_stall, payload i_in): each beat is a play
// note, an elapsed-time update or a one-microsecond tick. Output channel
// (o_out_valid / i_out_stall, payload o_out): exactly one result beat per input
// beat, holding the pin levels and busy flags after the update and the
// dropped-note flag.
// One item is worked at a time. A play note runs the bit-per-cycle divider and
// then loads the picked voice; an update or a tick runs a serial pass, one bit
// per cycle, over the 18-bit remaining time or the 19-bit tick count; a dropped
// note or an unused kind goes straight to the result. The next beat is taken in
// the cycle after the result is registered, so no new beat is taken before the
// last one is through.
// The result sits in an output register: the block takes and works the next
// beat while the receiver stalls, and waits at the end of that item until the
// register is free.
// Reset is synchronous and active low; it idles every voice, clears the pin
// and pending levels and empties the output register.
module two_voice_tone_generator_unit #(
    parameter int NUM_VOICES = tvtg_pkg::NUM_VOICES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  tvtg_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output tvtg_pkg::t_out o_out
);
    import tvtg_pkg::*;

    localparam int V2 = (NUM_VOICES > 1) ? 1 : 0;

    t_state                  r_state, n_state;
    logic [KIND_W-1:0]       r_kind;
    logic [EL_W-1:0]         r_el;
    logic [LEN_W-1:0]        r_len;
    logic [NUM_VOICES-1:0]   r_sel;
    logic                    r_drop;
    logic [K_W-1:0]          r_k;
    logic                    r_out_valid;
    t_out                    r_out;

    logic                    w_accept;
    logic                    w_start;
    logic                    w_out_load;
    logic                    w_k_last;
    logic                    w_found;
    logic [NUM_VOICES-1:0]   w_free;
    logic [NUM_VOICES-1:0]   w_pick;
    logic                    w_div_done;
    logic [CNT_W-1:0]        w_quot;
    t_vctl                   w_ctl  [NUM_VOICES];
    t_vstat                  w_stat [NUM_VOICES];
    t_out                    w_out_next;

    tvtg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_freq  (i_in.frequency),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    for (genvar v = 0; v < NUM_VOICES; v++) begin : g_voice
        assign w_free[v] = !w_stat[v].busy;

        always_comb begin
            w_ctl[v].load      = w_div_done && r_sel[v];
            w_ctl[v].half      = w_quot;
            w_ctl[v].len       = r_len;
            w_ctl[v].step_tick = (r_state == S_SER) && (r_kind == KIND_TICK);
            w_ctl[v].step_el   = (r_state == S_SER) && (r_kind == KIND_ELAPSED);
            w_ctl[v].first     = (r_k == '0);
            w_ctl[v].rem_last  = (r_k == K_W'(REM_W - 1));
            w_ctl[v].cnt_last  = (r_k == K_W'(CNT_W - 1));
            w_ctl[v].el_bit    = r_el[0];
        end

        tvtg_voice u_voice (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[v]),
            .o_stat  (w_stat[v])
        );
    end

    // Lowest-numbered free voice takes a new note.
    always_comb begin
        w_found = 1'b0;
        for (int v = 0; v < NUM_VOICES; v++) begin
            w_pick[v] = w_free[v] && !w_found;
            w_found   = w_found | w_free[v];
        end
    end

    always_comb begin
        w_k_last = (r_kind == KIND_TICK) ? (r_k == K_W'(CNT_W - 1))
                                         : (r_k == K_W'(REM_W - 1));
        w_out_next.speaker_one_level = w_stat[0].pin;
        w_out_next.speaker_two_level = w_stat[V2].pin & (NUM_VOICES > 1);
        w_out_next.voice_one_active  = w_stat[0].busy;
        w_out_next.voice_two_active  = w_stat[V2].busy & (NUM_VOICES > 1);
        w_out_next.note_dropped      = r_drop;
    end

    always_comb begin
        n_state    = r_state;
        w_accept   = 1'b0;
        w_start    = 1'b0;
        w_out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_accept = 1'b1;
                    case (i_in.kind) inside
                        KIND_PLAY: begin
                            if (|w_free) begin
                                w_start = 1'b1;
                                n_state = S_DIV;
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        KIND_ELAPSED, KIND_TICK: n_state = S_SER;
                        default:                 n_state = S_DONE;
                    endcase
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_DONE;
                end
            end
            S_SER: begin
                if (w_k_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= i_in.kind;
            r_el   <= i_in.elapsed;
            r_len  <= i_in.length;
            r_sel  <= w_pick;
            r_drop <= (i_in.kind == KIND_PLAY) && !(|w_free);
            r_k    <= '0;
        end else if (r_state == S_SER) begin
            r_k  <= r_k + 1'b1;
            r_el <= {1'b0, r_el[EL_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out <= w_out_next;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: rtl/tvtg_checker.sv
// Port-level checks for the tone generator, bound to the top level.
// Depends on tvtg_pkg and two_voice_tone_generator_unit.
module tvtg_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           i_in_stall,
    input logic           i_out_valid,
    input logic           i_out_stall,
    input tvtg_pkg::t_out i_out
);
    import tvtg_pkg::*;

    // A result beat waits until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid)
        else $error("result beat withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> $stable(i_out))
        else $error("stalled result beat changed");

    // Items are worked one at a time, so a taken beat blocks the next cycle.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !i_in_stall |=> i_in_stall)
        else $error("input taken twice in a row");

    // A note is dropped only when voice one is already playing.
    a_drop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out.note_dropped |-> i_out.voice_one_active)
        else $error("note dropped with voice one free");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind two_voice_tone_generator_unit tvtg_checker u_tvtg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out       (o_out)
);

// File: test/tone_result_checker.sv
`timescale 1ns / 100ps
// Result checker for the two-voice tone generator: watches both channels, runs
// an untimed model of the two voices and compares every result beat with it.
// Depends on tvtg_pkg.
module tone_result_checker
    import tvtg_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out,
    output int   o_pending,
    output int   o_fail_count,
    output int   o_drops,
    output int   o_pin_edges
);

    localparam int VOICES = NUM_VOICES_DEF;

    // Voice state of the model.
    logic        busy_q   [VOICES];
    int          remain_q [VOICES];
    int unsigned period_q [VOICES];
    int unsigned count_q  [VOICES];
    logic        pend_q   [VOICES];
    logic        pin_q    [VOICES];

    t_out levels_due [$];
    t_out model_out;
    logic dropped;
    int   free_slot;
    int unsigned note_hz;
    int   waiting = 0;
    int   fail_total = 0;
    int   drop_total = 0;
    int   edge_total = 0;

    assign o_pending    = waiting;
    assign o_fail_count = fail_total;
    assign o_drops      = drop_total;
    assign o_pin_edges  = edge_total;

    function automatic void compare_level(input string name, input logic want, input logic got);
        if (got !== want) begin
            $error("result field %s: expected %0b, got %0b", name, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                busy_q[v]   = 1'b0;
                remain_q[v] = 0;
                period_q[v] = 0;
                count_q[v]  = 0;
                pend_q[v]   = 1'b0;
                pin_q[v]    = 1'b0;
            end
            levels_due.delete();
            waiting <= 0;
        end else begin
            // The result side goes first: a beat taken in this cycle cannot have
            // its result out in the same cycle.
            if (i_out_valid && !i_out_stall) begin
                if (levels_due.size() == 0) begin
                    $error("result beat arrived with no prediction waiting for it");
                    fail_total++;
                end else begin
                    model_out = levels_due.pop_front();
                    compare_level("speaker_one_level", model_out.speaker_one_level,
                                  i_out.speaker_one_level);
                    compare_level("speaker_two_level", model_out.speaker_two_level,
                                  i_out.speaker_two_level);
                    compare_level("voice_one_active", model_out.voice_one_active,
                                  i_out.voice_one_active);
                    compare_level("voice_two_active", model_out.voice_two_active,
                                  i_out.voice_two_active);
                    compare_level("note_dropped", model_out.note_dropped,
                                  i_out.note_dropped);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                dropped = 1'b0;
                case (i_in.kind)
                    KIND_PLAY: begin
                        free_slot = -1;
                        for (int v = VOICES - 1; v >= 0; v--) begin
                            if (!busy_q[v]) free_slot = v;
                        end
                        if (free_slot >= 0) begin
                            // A zero frequency plays as 1 Hz.
                            note_hz = (i_in.frequency == '0) ? 1 : i_in.frequency;
                            period_q[free_slot] = TICKS_PER_SEC / (2 * note_hz);
                            remain_q[free_slot] = int'(i_in.length);
                            busy_q[free_slot]   = 1'b1;
                            count_q[free_slot]  = 0;
                        end else begin
                            dropped = 1'b1;
                            drop_total++;
                        end
                    end
                    KIND_ELAPSED: begin
                        for (int v = 0; v < VOICES; v++) begin
                            if (busy_q[v]) begin
                                remain_q[v] = remain_q[v] - int'(i_in.elapsed);
                                if (remain_q[v] <= 0) busy_q[v] = 1'b0;
                            end
                        end
                    end
                    KIND_TICK: begin
                        for (int v = 0; v < VOICES; v++) begin
                            if (busy_q[v]) begin
                                count_q[v] = (count_q[v] + 1) & ((32'd1 << CNT_W) - 1);
                                if (count_q[v] >= period_q[v]) begin
                                    count_q[v] = 0;
                                    if (pin_q[v] != pend_q[v]) edge_total++;
                                    pin_q[v]  = pend_q[v];
                                    pend_q[v] = ~pend_q[v];
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
                model_out.speaker_one_level = pin_q[0];
                model_out.speaker_two_level = pin_q[1];
                model_out.voice_one_active  = busy_q[0];
                model_out.voice_two_active  = busy_q[1];
                model_out.note_dropped      = dropped;
                levels_due.push_back(model_out);
            end
            waiting <= levels_due.size();
        end
    end

endmodule

// File: test/two_voice_tone_generator_unit_test.sv
`timescale 1ns / 100ps
// Top of the two-voice tone generator regression: clock, reset, note, update and
// tick stimulus with random idling on both channels, and the verdict.
// Depends on tvtg_pkg, two_voice_tone_generator_unit and tone_result_checker.
module two_voice_tone_generator_unit_test;
    import tvtg_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int ITEM_TARGET  = 1500;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_in  i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_out o_out;

    // While calm is set neither side inserts gaps.
    logic calm = 1'b0;
    int unsigned stall_hold = 0;
    int idle_cycles = 0;
    int pending;
    int fail_count;
    int drops;
    int pin_edges;
    int sent = 0;
    int notes = 0;
    int updates = 0;
    int ticks = 0;
    int unused_beats = 0;

    always #2 i_clk = ~i_clk;

    two_voice_tone_generator_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    tone_result_checker results_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in         (i_in),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out        (o_out),
        .o_pending    (pending),
        .o_fail_count (fail_count),
        .o_drops      (drops),
        .o_pin_edges  (pin_edges)
    );

    // Receiver stalls: mostly short, now and then a long one.
    always @(posedge i_clk) begin
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if (!calm && $urandom_range(0, 99) < 25) begin
            i_out_stall <= 1'b1;
            stall_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60)
                                                       : $urandom_range(0, 3);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("two_voice_tone_generator_unit regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [FREQ_W-1:0] hz,
                             input logic [LEN_W-1:0] len, input logic [EL_W-1:0] el);
        int unsigned gap;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55) gap = 0;
        else if (roll < 92) gap = $urandom_range(1, 3);
        else gap = $urandom_range(15, 60);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in <= {kind, hz, len, el};
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        sent++;
        case (kind)
            KIND_PLAY:    notes++;
            KIND_ELAPSED: updates++;
            KIND_TICK:    ticks++;
            default:      unused_beats++;
        endcase
    endtask

    // Hold the sender off until every predicted result has been taken.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int unsigned roll;
        int unsigned burst;
        logic [FREQ_W-1:0] hz;
        logic [LEN_W-1:0] len;
        logic [EL_W-1:0] el;
        bit drained_mid;
        drained_mid = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: reset state, zero length, zero and top frequency,
        // dropping, exact and negative expiry, restart of a voice.
        send_beat(KIND_UNUSED, '0, '0, '0);
        send_beat(KIND_ELAPSED, '0, '0, '1);
        send_beat(KIND_PLAY, '1, '0, '0);
        send_beat(KIND_TICK, '0, '0, '0);
        send_beat(KIND_ELAPSED, '1, '1, '0);
        send_beat(KIND_PLAY, '0, '1, '1);
        send_beat(KIND_PLAY, 15'd20000, 16'd3, '0);
        send_beat(KIND_PLAY, 15'd1, 16'd5, '1);
        send_beat(KIND_UNUSED, '1, '1, '1);
        send_beat(KIND_TICK, '1, '1, '1);
        send_beat(KIND_ELAPSED, '0, '0, 16'd2);
        send_beat(KIND_ELAPSED, '0, '0, 16'd1);
        send_beat(KIND_PLAY, 15'd16384, 16'd1, '0);
        send_beat(KIND_TICK, '0, '0, '0);
        send_beat(KIND_PLAY, 15'd32767, 16'h8000, '0);
        send_beat(KIND_ELAPSED, '0, '0, '1);
        wait_drained();

        // Random part: notes at high pitches with long tick bursts, so that the
        // speaker pins actually toggle, mixed with updates and noise.
        while (sent < ITEM_TARGET) begin
            calm <= ((sent / 300) % 4) == 3;
            if (!drained_mid && sent >= ITEM_TARGET / 2) begin
                wait_drained();
                drained_mid = 1'b1;
            end
            roll = $urandom_range(0, 99);
            hz   = FREQ_W'($urandom_range(0, 32767));
            len  = LEN_W'($urandom_range(0, 65535));
            el   = EL_W'($urandom_range(0, 65535));
            if (roll < 15) begin
                if ($urandom_range(0, 7) != 0) begin
                    hz  = FREQ_W'($urandom_range(10000, 32767));
                    len = LEN_W'($urandom_range(0, 3000));
                end
                send_beat(KIND_PLAY, hz, len, el);
            end else if (roll < 35) begin
                if ($urandom_range(0, 9) != 0) el = EL_W'($urandom_range(0, 400));
                send_beat(KIND_ELAPSED, hz, len, el);
            end else if (roll < 38) begin
                send_beat(KIND_UNUSED, hz, len, el);
            end else begin
                burst = $urandom_range(1, 40);
                repeat (burst) begin
                    send_beat(KIND_TICK, FREQ_W'($urandom_range(0, 32767)),
                              LEN_W'($urandom_range(0, 65535)),
                              EL_W'($urandom_range(0, 65535)));
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d beats: %0d notes (%0d dropped), %0d updates, %0d ticks, %0d unused.",
                 sent, notes, drops, updates, ticks, unused_beats);
        $display("Speaker pins changed level %0d times.", pin_edges);
        if (fail_count == 0) begin
            $display("two_voice_tone_generator_unit regression: pass");
        end else begin
            $display("two_voice_tone_generator_unit regression: fail");
        end
        $finish;
    end

endmodule
